// ===== hdl/lsb_pkg.sv =====
// Shared types, codes and constants of the lockstep step barrier.
// Used by every module of the block; depends on nothing.
package lsb_pkg;

  localparam int STEP_BITS = 32;
  localparam int SEC_BITS = 34;
  localparam logic [30:0] NS_PER_SEC = 31'd1000000000;
  localparam logic [30:0] NS_TWO_SEC = 31'd2000000000;
  localparam logic [30:0] SEC_MAX = 31'h7fffffff;
  localparam logic [29:0] STEP_SIZE_RESET = 30'd1000000;

  typedef enum logic [1:0] {
    CMD_OBS = 2'd0,
    CMD_CTRL = 2'd1,
    CMD_QUEUED = 2'd2,
    CMD_PLANT = 2'd3
  } cmd_t;

  localparam logic [2:0] OC_WRONGGEN = 3'd0;
  localparam logic [2:0] OC_STALE = 3'd1;
  localparam logic [2:0] OC_DUP = 3'd2;
  localparam logic [2:0] OC_ACCEPT = 3'd3;
  localparam logic [2:0] OC_GRANT = 3'd4;
  localparam logic [2:0] OC_COMMIT = 3'd5;
  localparam logic [2:0] OC_ABORT = 3'd6;

  localparam logic [4:0] AR_NONE = 5'd0;
  localparam logic [4:0] AR_OBS_PHASE = 5'd1;
  localparam logic [4:0] AR_OBS_MISMATCH = 5'd2;
  localparam logic [4:0] AR_OBS_ID = 5'd3;
  localparam logic [4:0] AR_CTRL_PLANT = 5'd4;
  localparam logic [4:0] AR_CTRL_PHASE = 5'd5;
  localparam logic [4:0] AR_CTRL_SRC = 5'd6;
  localparam logic [4:0] AR_CTRL_TGT = 5'd7;
  localparam logic [4:0] AR_CTRL_CMD = 5'd8;
  localparam logic [4:0] AR_CTRL_DUP = 5'd9;
  localparam logic [4:0] AR_Q_PLANT = 5'd10;
  localparam logic [4:0] AR_Q_PHASE = 5'd11;
  localparam logic [4:0] AR_Q_REJECT = 5'd12;
  localparam logic [4:0] AR_Q_CMD = 5'd13;
  localparam logic [4:0] AR_Q_TGT = 5'd14;
  localparam logic [4:0] AR_Q_DUP = 5'd15;
  localparam logic [4:0] AR_BARRIER = 5'd16;
  localparam logic [4:0] AR_PREPARE = 5'd17;
  localparam logic [4:0] AR_PREP_STEP = 5'd18;
  localparam logic [4:0] AR_PL_PHASE = 5'd19;
  localparam logic [4:0] AR_PL_FAIL = 5'd20;
  localparam logic [4:0] AR_PL_TARGET = 5'd21;
  localparam logic [4:0] AR_PL_ITER = 5'd22;
  localparam logic [4:0] AR_PL_TIME = 5'd23;
  localparam logic [4:0] AR_PL_APPLIED = 5'd24;
  localparam logic [4:0] AR_PL_APP_TGT = 5'd25;

  localparam logic [2:0] REG_STEP_SIZE = 3'd0;
  localparam logic [2:0] REG_GENERATION = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] msg_generation;
    logic [31:0] step;
    logic [31:0] src_step;
    logic [62:0] time_ns;
    logic [31:0] cmd_id;
    logic [63:0] obs_id;
    logic        ok_flag;
    logic [31:0] plant_iter;
    logic [62:0] plant_time_ns;
    logic [31:0] applied_cmd;
  } in_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [4:0]  abort_reason;
    logic [31:0] out_step;
    logic [62:0] out_time_ns;
    logic [31:0] out_cmd_id;
    logic [63:0] out_obs_id;
    logic [30:0] clock_sec;
    logic [29:0] clock_nanosec;
  } out_t;

  typedef struct packed {
    logic wrong_gen;
    cmd_t kind;
    in_t  msg;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// ===== hdl/lsb_front.sv =====
// Front end: accepts messages, tags generation and kind, and queues them.
// Depends on lsb_pkg.
module lsb_front import lsb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  input  logic [31:0] cur_gen,
  output head_t       head,
  input  logic        pop
);

  entry_t     mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr].wrong_gen <= (in_data.msg_generation != cur_gen);
      mem[wptr].kind <= cmd_t'(in_data.command);
      mem[wptr].msg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.entry = mem[rptr];

endmodule

// ===== hdl/lsb_back.sv =====
// Back end: runs the lockstep machine and barrier on each queued message.
// Holds the result register of the output channel. Depends on lsb_pkg.
module lsb_back import lsb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  head_t       head,
  output logic        pop,
  input  logic [29:0] step_ns,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  typedef enum logic [1:0] {
    PH_OBS = 2'd0,
    PH_CTRL = 2'd1,
    PH_PLANT = 2'd2,
    PH_ABORT = 2'd3
  } phase_t;

  phase_t                 phase, phase_next;
  logic [STEP_BITS-1:0]   commit_step, commit_step_next;
  logic [62:0]            committed_time, committed_time_next;
  logic [SEC_BITS-1:0]    committed_sec, committed_sec_next;
  logic [29:0]            committed_nsec, committed_nsec_next;
  logic [STEP_BITS-1:0]   pend_step, pend_step_next;
  logic [62:0]            pending_time, pending_time_next;
  logic [SEC_BITS-1:0]    pending_sec, pending_sec_next;
  logic [29:0]            pending_nsec, pending_nsec_next;
  logic                   ctrl_valid, ctrl_valid_next;
  logic [31:0]            ctrl_src, ctrl_src_next;
  logic [31:0]            ctrl_tgt, ctrl_tgt_next;
  logic [31:0]            ctrl_cmd, ctrl_cmd_next;
  logic                   q_valid, q_valid_next;
  logic [31:0]            q_tgt, q_tgt_next;
  logic [31:0]            q_cmd, q_cmd_next;
  logic                   q_ok, q_ok_next;
  logic [31:0]            exp_tgt, exp_tgt_next;
  logic [31:0]            exp_cmd, exp_cmd_next;
  logic                   exp_obs_valid, exp_obs_valid_next;
  logic [63:0]            exp_obs_id, exp_obs_id_next;
  out_t                   res;

  in_t                    m;
  logic [STEP_BITS-1:0]   step_inc;
  logic                   step_max;
  logic                   is_next;
  logic                   stale;
  logic [63:0]            tsum;
  logic [30:0]            nsum;
  logic [29:0]            nsec_prep;
  logic [SEC_BITS-1:0]    sec_prep;
  logic                   do_barrier;
  logic [31:0]            b_ctgt, b_ccmd, b_qtgt, b_qcmd;

  assign pop = head.valid && (!out_valid || !out_stall);
  assign m = head.entry.msg;
  assign step_inc = commit_step + STEP_BITS'(1);
  assign step_max = (commit_step == {STEP_BITS{1'b1}});
  assign is_next = !step_max && (STEP_BITS'(m.step) == step_inc);
  assign stale = (STEP_BITS'(m.step) <= commit_step);
  assign tsum = {1'b0, committed_time} + {34'd0, step_ns};
  assign nsum = {1'b0, committed_nsec} + {1'b0, step_ns};

  always_comb begin
    priority if (nsum >= NS_TWO_SEC) begin
      nsec_prep = 30'(nsum - NS_TWO_SEC);
      sec_prep = committed_sec + SEC_BITS'(2);
    end else if (nsum >= NS_PER_SEC) begin
      nsec_prep = 30'(nsum - NS_PER_SEC);
      sec_prep = committed_sec + SEC_BITS'(1);
    end else begin
      nsec_prep = nsum[29:0];
      sec_prep = committed_sec;
    end
  end

  always_comb begin
    phase_next = phase;
    commit_step_next = commit_step;
    committed_time_next = committed_time;
    committed_sec_next = committed_sec;
    committed_nsec_next = committed_nsec;
    pend_step_next = pend_step;
    pending_time_next = pending_time;
    pending_sec_next = pending_sec;
    pending_nsec_next = pending_nsec;
    ctrl_valid_next = ctrl_valid;
    ctrl_src_next = ctrl_src;
    ctrl_tgt_next = ctrl_tgt;
    ctrl_cmd_next = ctrl_cmd;
    q_valid_next = q_valid;
    q_tgt_next = q_tgt;
    q_cmd_next = q_cmd;
    q_ok_next = q_ok;
    exp_tgt_next = exp_tgt;
    exp_cmd_next = exp_cmd;
    exp_obs_valid_next = exp_obs_valid;
    exp_obs_id_next = exp_obs_id;
    res = '0;
    do_barrier = 1'b0;
    b_ctgt = ctrl_tgt;
    b_ccmd = ctrl_cmd;
    b_qtgt = q_tgt;
    b_qcmd = q_cmd;

    if (head.entry.wrong_gen) begin
      res.outcome = OC_WRONGGEN;
    end else begin
      unique case (head.entry.kind)
        CMD_OBS: begin
          priority if (phase != PH_OBS) begin
            res.abort_reason = AR_OBS_PHASE;
          end else if (STEP_BITS'(m.step) != commit_step || m.time_ns != committed_time)
              begin
            res.abort_reason = AR_OBS_MISMATCH;
          end else if (exp_obs_valid && m.obs_id != exp_obs_id) begin
            res.abort_reason = AR_OBS_ID;
          end else begin
            exp_obs_valid_next = 1'b0;
            ctrl_valid_next = 1'b0;
            q_valid_next = 1'b0;
            phase_next = PH_CTRL;
            res.outcome = OC_ACCEPT;
          end
        end
        CMD_CTRL: begin
          priority if (stale) begin
            res.outcome = OC_STALE;
          end else if (phase == PH_PLANT) begin
            if (m.step == exp_tgt && m.cmd_id == exp_cmd) res.outcome = OC_DUP;
            else res.abort_reason = AR_CTRL_PLANT;
          end else if (phase != PH_CTRL) begin
            res.abort_reason = AR_CTRL_PHASE;
          end else if (STEP_BITS'(m.src_step) != commit_step) begin
            res.abort_reason = AR_CTRL_SRC;
          end else if (!is_next) begin
            res.abort_reason = AR_CTRL_TGT;
          end else if (m.cmd_id != m.step) begin
            res.abort_reason = AR_CTRL_CMD;
          end else if (ctrl_valid) begin
            if (ctrl_src == m.src_step && ctrl_tgt == m.step && ctrl_cmd == m.cmd_id)
              res.outcome = OC_DUP;
            else res.abort_reason = AR_CTRL_DUP;
          end else begin
            ctrl_valid_next = 1'b1;
            ctrl_src_next = m.src_step;
            ctrl_tgt_next = m.step;
            ctrl_cmd_next = m.cmd_id;
            b_ctgt = m.step;
            b_ccmd = m.cmd_id;
            if (q_valid) do_barrier = 1'b1;
            else res.outcome = OC_ACCEPT;
          end
        end
        CMD_QUEUED: begin
          priority if (stale) begin
            res.outcome = OC_STALE;
          end else if (phase == PH_PLANT) begin
            if (m.ok_flag && m.step == exp_tgt && m.cmd_id == exp_cmd)
              res.outcome = OC_DUP;
            else res.abort_reason = AR_Q_PLANT;
          end else if (phase != PH_CTRL) begin
            res.abort_reason = AR_Q_PHASE;
          end else if (!m.ok_flag) begin
            res.abort_reason = AR_Q_REJECT;
          end else if (m.cmd_id != m.step) begin
            res.abort_reason = AR_Q_CMD;
          end else if (!is_next) begin
            res.abort_reason = AR_Q_TGT;
          end else if (q_valid) begin
            if (q_tgt == m.step && q_cmd == m.cmd_id && q_ok == m.ok_flag)
              res.outcome = OC_DUP;
            else res.abort_reason = AR_Q_DUP;
          end else begin
            q_valid_next = 1'b1;
            q_tgt_next = m.step;
            q_cmd_next = m.cmd_id;
            q_ok_next = m.ok_flag;
            b_qtgt = m.step;
            b_qcmd = m.cmd_id;
            if (ctrl_valid) do_barrier = 1'b1;
            else res.outcome = OC_ACCEPT;
          end
        end
        CMD_PLANT: begin
          priority if (phase != PH_PLANT) begin
            res.abort_reason = AR_PL_PHASE;
          end else if (!m.ok_flag) begin
            res.abort_reason = AR_PL_FAIL;
          end else if (STEP_BITS'(m.step) != pend_step || m.time_ns != pending_time) begin
            res.abort_reason = AR_PL_TARGET;
          end else if (STEP_BITS'(m.plant_iter) != pend_step) begin
            res.abort_reason = AR_PL_ITER;
          end else if (m.plant_time_ns != pending_time) begin
            res.abort_reason = AR_PL_TIME;
          end else if (m.applied_cmd != exp_cmd) begin
            res.abort_reason = AR_PL_APPLIED;
          end else if (m.applied_cmd != m.step) begin
            res.abort_reason = AR_PL_APP_TGT;
          end else begin
            commit_step_next = pend_step;
            committed_time_next = pending_time;
            committed_sec_next = pending_sec;
            committed_nsec_next = pending_nsec;
            exp_obs_valid_next = 1'b1;
            exp_obs_id_next = m.obs_id;
            phase_next = PH_OBS;
            res.outcome = OC_COMMIT;
            res.out_step = 32'(pend_step);
            res.out_time_ns = pending_time;
            res.out_cmd_id = m.applied_cmd;
            res.out_obs_id = m.obs_id;
            res.clock_sec = (pending_sec > SEC_BITS'(SEC_MAX)) ? SEC_MAX
                                                                : 31'(pending_sec);
            res.clock_nanosec = pending_nsec;
          end
        end
        default: res.outcome = OC_WRONGGEN;
      endcase
    end

    if (do_barrier) begin
      priority if (b_ctgt != b_qtgt || b_ccmd != b_qcmd) begin
        res.abort_reason = AR_BARRIER;
      end else begin
        exp_tgt_next = b_ctgt;
        exp_cmd_next = b_ccmd;
        priority if (tsum[63] || step_max) begin
          res.abort_reason = AR_PREPARE;
        end else begin
          pend_step_next = step_inc;
          pending_time_next = tsum[62:0];
          pending_sec_next = sec_prep;
          pending_nsec_next = nsec_prep;
          if (32'(step_inc) != b_ctgt) begin
            res.abort_reason = AR_PREP_STEP;
          end else begin
            ctrl_valid_next = 1'b0;
            q_valid_next = 1'b0;
            phase_next = PH_PLANT;
            res.outcome = OC_GRANT;
            res.out_step = 32'(step_inc);
            res.out_time_ns = tsum[62:0];
            res.out_cmd_id = 32'(step_inc);
          end
        end
      end
    end

    if (res.abort_reason != AR_NONE) begin
      res.outcome = OC_ABORT;
      phase_next = PH_ABORT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_OBS;
      commit_step <= '0;
      committed_time <= '0;
      committed_sec <= '0;
      committed_nsec <= '0;
      pend_step <= '0;
      pending_time <= '0;
      pending_sec <= '0;
      pending_nsec <= '0;
      ctrl_valid <= 1'b0;
      q_valid <= 1'b0;
      exp_tgt <= '0;
      exp_cmd <= '0;
      exp_obs_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase <= phase_next;
        commit_step <= commit_step_next;
        committed_time <= committed_time_next;
        committed_sec <= committed_sec_next;
        committed_nsec <= committed_nsec_next;
        pend_step <= pend_step_next;
        pending_time <= pending_time_next;
        pending_sec <= pending_sec_next;
        pending_nsec <= pending_nsec_next;
        ctrl_valid <= ctrl_valid_next;
        q_valid <= q_valid_next;
        exp_tgt <= exp_tgt_next;
        exp_cmd <= exp_cmd_next;
        exp_obs_valid <= exp_obs_valid_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ctrl_src <= ctrl_src_next;
      ctrl_tgt <= ctrl_tgt_next;
      ctrl_cmd <= ctrl_cmd_next;
      q_tgt <= q_tgt_next;
      q_cmd <= q_cmd_next;
      q_ok <= q_ok_next;
      exp_obs_id <= exp_obs_id_next;
      out_data <= res;
    end
  end

  a_abort_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ABORT |=> phase == PH_ABORT)
    else $error("aborted phase left");

  a_grant_plant: assert property (@(posedge clk) disable iff (rst)
    pop && res.outcome == OC_GRANT |=> phase == PH_PLANT && !ctrl_valid && !q_valid)
    else $error("grant did not enter plant phase");

  a_commit_obs: assert property (@(posedge clk) disable iff (rst)
    pop && res.outcome == OC_COMMIT |=> phase == PH_OBS && exp_obs_valid)
    else $error("commit did not arm observation");

  a_nsec_range: assert property (@(posedge clk) disable iff (rst)
    committed_nsec < 30'(NS_PER_SEC) && pending_nsec < 30'(NS_PER_SEC))
    else $error("nanosecond split out of range");

endmodule

// ===== hdl/lockstep_step_barrier.sv =====
// Top level of the lockstep step barrier: register port, front end, back end.
// Depends on lsb_pkg, lsb_front and lsb_back.
//
//  channel  handshake            payload
//  in       in_valid / in_stall  in_data  (in_t)
//  out      out_valid/ out_stall out_data (out_t)
//  cfg      psel/penable/pready  paddr, pwdata, prdata
//
// One message per cycle while out_stall is low; out_data is registered.
// The seconds/nanoseconds split is kept incrementally, one add and two compares.
// Reset is synchronous; state is ready the cycle after rst falls.
// A held out_stall fills the two-entry queue, then in_stall rises.
module lockstep_step_barrier import lsb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [29:0] step_ns;
  logic [31:0] cur_gen;
  head_t       head;
  logic        pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ns <= STEP_SIZE_RESET;
      cur_gen <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) cur_gen <= pwdata;
      else step_ns <= pwdata[29:0];
    end
  end

  always_comb begin
    if (paddr == REG_STEP_SIZE) prdata = {2'd0, step_ns};
    else if (paddr == REG_GENERATION) prdata = cur_gen;
    else prdata = '0;
  end

  lsb_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .cur_gen(cur_gen),
    .head(head),
    .pop(pop)
  );

  lsb_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .pop(pop),
    .step_ns(step_ns),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule

// ===== dv/lockstep_step_barrier_tb.sv =====
// Self-checking testbench for the lockstep step barrier: a shadow model of the
// phase machine predicts every result, checked in order against the output.
// Depends on lsb_pkg and the lockstep_step_barrier top level.
`timescale 1ns / 1ps

module lockstep_step_barrier_tb;
  import lsb_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 80;

  typedef enum logic [1:0] {
    AWAIT_OBS, AWAIT_BARRIER, AWAIT_PLANT, HALTED
  } lock_phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lockstep_step_barrier uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow configuration and state
  logic [29:0] cfg_step_ns = STEP_SIZE_RESET;
  logic [31:0] cfg_gen = '0;
  lock_phase_e ph = AWAIT_OBS;
  logic [31:0] cstep = '0, pstep = '0;
  logic [62:0] ctime = '0, ptime = '0;
  logic ctrl_v = 1'b0, q_v = 1'b0, obs_v = 1'b0;
  logic [31:0] ctrl_src, ctrl_tgt, ctrl_cmd, q_tgt, q_cmd;
  logic q_ok;
  logic [31:0] tgt_step = '0, tgt_cmd = '0;
  logic [63:0] obs_id_due;

  out_t result_q[$];
  int errors = 0;
  int mismatches = 0;
  int n_sent = 0, n_commits = 0, n_aborts = 0, n_grants = 0;
  int idle_cycles = 0;
  int burst_left = 4;
  bit offering = 1'b0;
  int hold_reqs = 0, hold_seen = 0, hold_cnt = 0;
  int stall_mode = 0, mode_cnt = 0;

  function automatic out_t abort_with(logic [4:0] why);
    out_t r;
    r = '0;
    ph = HALTED;
    r.outcome = OC_ABORT;
    r.abort_reason = why;
    n_aborts++;
    return r;
  endfunction

  function automatic bit next_step_ok(logic [31:0] s);
    return cstep != '1 && s == cstep + 32'd1;
  endfunction

  function automatic out_t join_barrier();
    out_t r;
    logic [63:0] t;
    r = '0;
    if (ph != AWAIT_BARRIER || !ctrl_v || !q_v) begin
      r.outcome = OC_ACCEPT;
      return r;
    end
    if (ctrl_tgt != q_tgt || ctrl_cmd != q_cmd) return abort_with(AR_BARRIER);
    tgt_step = ctrl_tgt;
    tgt_cmd = ctrl_cmd;
    t = {1'b0, ctime} + {34'b0, cfg_step_ns};
    if (t[63] || cstep == '1) return abort_with(AR_PREPARE);
    pstep = cstep + 32'd1;
    ptime = t[62:0];
    if (pstep != tgt_step) return abort_with(AR_PREP_STEP);
    ctrl_v = 1'b0;
    q_v = 1'b0;
    ph = AWAIT_PLANT;
    r.outcome = OC_GRANT;
    r.out_step = pstep;
    r.out_time_ns = ptime;
    r.out_cmd_id = pstep;
    n_grants++;
    return r;
  endfunction

  function automatic out_t predict_outcome(in_t m);
    out_t r;
    logic [63:0] sec;
    r = '0;
    if (m.msg_generation != cfg_gen) begin
      r.outcome = OC_WRONGGEN;
      return r;
    end
    case (cmd_t'(m.command))
      CMD_OBS: begin
        if (ph != AWAIT_OBS) return abort_with(AR_OBS_PHASE);
        if (m.step != cstep || m.time_ns != ctime) return abort_with(AR_OBS_MISMATCH);
        if (obs_v && m.obs_id != obs_id_due) return abort_with(AR_OBS_ID);
        obs_v = 1'b0;
        ctrl_v = 1'b0;
        q_v = 1'b0;
        ph = AWAIT_BARRIER;
        r.outcome = OC_ACCEPT;
        return r;
      end
      CMD_CTRL: begin
        if (m.step <= cstep) begin
          r.outcome = OC_STALE;
          return r;
        end
        if (ph == AWAIT_PLANT) begin
          if (m.step == tgt_step && m.cmd_id == tgt_cmd) begin
            r.outcome = OC_DUP;
            return r;
          end
          return abort_with(AR_CTRL_PLANT);
        end
        if (ph != AWAIT_BARRIER) return abort_with(AR_CTRL_PHASE);
        if (m.src_step != cstep) return abort_with(AR_CTRL_SRC);
        if (!next_step_ok(m.step)) return abort_with(AR_CTRL_TGT);
        if (m.cmd_id != m.step) return abort_with(AR_CTRL_CMD);
        if (ctrl_v) begin
          if (ctrl_src == m.src_step && ctrl_tgt == m.step && ctrl_cmd == m.cmd_id) begin
            r.outcome = OC_DUP;
            return r;
          end
          return abort_with(AR_CTRL_DUP);
        end
        ctrl_v = 1'b1;
        ctrl_src = m.src_step;
        ctrl_tgt = m.step;
        ctrl_cmd = m.cmd_id;
        return join_barrier();
      end
      CMD_QUEUED: begin
        if (m.step <= cstep) begin
          r.outcome = OC_STALE;
          return r;
        end
        if (ph == AWAIT_PLANT) begin
          if (m.ok_flag && m.step == tgt_step && m.cmd_id == tgt_cmd) begin
            r.outcome = OC_DUP;
            return r;
          end
          return abort_with(AR_Q_PLANT);
        end
        if (ph != AWAIT_BARRIER) return abort_with(AR_Q_PHASE);
        if (!m.ok_flag) return abort_with(AR_Q_REJECT);
        if (m.cmd_id != m.step) return abort_with(AR_Q_CMD);
        if (!next_step_ok(m.step)) return abort_with(AR_Q_TGT);
        if (q_v) begin
          if (q_tgt == m.step && q_cmd == m.cmd_id && q_ok == m.ok_flag) begin
            r.outcome = OC_DUP;
            return r;
          end
          return abort_with(AR_Q_DUP);
        end
        q_v = 1'b1;
        q_tgt = m.step;
        q_cmd = m.cmd_id;
        q_ok = m.ok_flag;
        return join_barrier();
      end
      default: begin
        if (ph != AWAIT_PLANT) return abort_with(AR_PL_PHASE);
        if (!m.ok_flag) return abort_with(AR_PL_FAIL);
        if (m.step != pstep || m.time_ns != ptime) return abort_with(AR_PL_TARGET);
        if (m.plant_iter != pstep) return abort_with(AR_PL_ITER);
        if (m.plant_time_ns != ptime) return abort_with(AR_PL_TIME);
        if (m.applied_cmd != tgt_cmd) return abort_with(AR_PL_APPLIED);
        if (m.applied_cmd != m.step) return abort_with(AR_PL_APP_TGT);
        cstep = pstep;
        ctime = ptime;
        obs_v = 1'b1;
        obs_id_due = m.obs_id;
        ph = AWAIT_OBS;
        r.outcome = OC_COMMIT;
        r.out_step = cstep;
        r.out_time_ns = ctime;
        r.out_cmd_id = m.applied_cmd;
        r.out_obs_id = m.obs_id;
        sec = {1'b0, ctime} / 64'd1000000000;
        r.clock_sec = (sec > {33'b0, SEC_MAX}) ? SEC_MAX : sec[30:0];
        r.clock_nanosec = 30'({1'b0, ctime} % 64'd1000000000);
        n_commits++;
        return r;
      end
    endcase
  endfunction

  function automatic in_t rand_msg();
    in_t m;
    m.command = 2'($urandom_range(0, 3));
    m.msg_generation = $urandom;
    m.step = $urandom;
    m.src_step = $urandom;
    m.time_ns = 63'({$urandom, $urandom});
    m.cmd_id = $urandom;
    m.obs_id = {$urandom, $urandom};
    m.ok_flag = 1'($urandom);
    m.plant_iter = $urandom;
    m.plant_time_ns = 63'({$urandom, $urandom});
    m.applied_cmd = $urandom;
    return m;
  endfunction

  // well-formed message of the given kind for the current shadow state
  function automatic in_t good_msg(cmd_t k);
    in_t m;
    m = rand_msg();
    m.command = k;
    m.msg_generation = cfg_gen;
    case (k)
      CMD_OBS: begin
        m.step = cstep;
        m.time_ns = ctime;
        if (obs_v) m.obs_id = obs_id_due;
      end
      CMD_CTRL: begin
        m.src_step = cstep;
        m.step = cstep + 32'd1;
        m.cmd_id = cstep + 32'd1;
      end
      CMD_QUEUED: begin
        m.step = cstep + 32'd1;
        m.cmd_id = cstep + 32'd1;
        m.ok_flag = 1'b1;
      end
      default: begin
        m.step = pstep;
        m.time_ns = ptime;
        m.ok_flag = 1'b1;
        m.plant_iter = pstep;
        m.plant_time_ns = ptime;
        m.applied_cmd = pstep;
      end
    endcase
    return m;
  endfunction

  function automatic in_t noise_msg();
    in_t m;
    m = rand_msg();
    if ($urandom_range(0, 1)) begin
      m.msg_generation = cfg_gen ^ (32'd1 << $urandom_range(0, 31));
    end else begin
      m.msg_generation = cfg_gen;
      m.command = $urandom_range(0, 1) ? CMD_CTRL : CMD_QUEUED;
      m.step = $urandom_range(0, cstep);
    end
    return m;
  endfunction

  task automatic send_msg(in_t m);
    if (!offering) in_valid <= 1'b1;
    in_data <= m;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    result_q.push_back(predict_outcome(m));
    n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? 120 : $urandom_range(1, 20);
    end
  endtask

  task automatic settle();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_STEP_SIZE) cfg_step_ns = value[29:0];
    else cfg_gen = value;
    @(posedge clk);
  endtask

  task automatic run_cycle();
    send_msg(good_msg(CMD_OBS));
    if ($urandom_range(0, 1)) begin
      send_msg(good_msg(CMD_CTRL));
      send_msg(good_msg(CMD_QUEUED));
    end else begin
      send_msg(good_msg(CMD_QUEUED));
      send_msg(good_msg(CMD_CTRL));
    end
    send_msg(good_msg(CMD_PLANT));
  endtask

  task automatic test_field_extremes();
    in_t m;
    m = '0;
    m.msg_generation = cfg_gen ^ 32'h8000_0001;
    for (int k = 0; k < 4; k++) begin
      m.command = 2'(k);
      send_msg(m);
    end
    m = '1;
    m.msg_generation = ~cfg_gen;
    send_msg(m);
    m = noise_msg();
    m.msg_generation = cfg_gen;
    m.command = CMD_CTRL;
    m.step = '0;
    send_msg(m);
    m.command = CMD_QUEUED;
    send_msg(m);
    settle();
  endtask

  task automatic test_basic_cycle();
    send_msg(good_msg(CMD_OBS));
    send_msg(good_msg(CMD_CTRL));
    send_msg(good_msg(CMD_CTRL));
    send_msg(good_msg(CMD_QUEUED));
    send_msg(good_msg(CMD_QUEUED));
    send_msg(good_msg(CMD_CTRL));
    send_msg(good_msg(CMD_PLANT));
    run_cycle();
    settle();
  endtask

  task automatic test_config_sweep();
    logic [29:0] sizes [4];
    logic [31:0] gens [4];
    in_t m;
    sizes = '{30'd0, 30'd1, 30'd1000000000, 30'($urandom_range(1, 1000000000))};
    gens = '{32'hFFFF_FFFF, 32'h0, $urandom, 32'h0};
    for (int i = 0; i < 4; i++) begin
      write_reg(REG_STEP_SIZE, {2'b0, sizes[i]});
      write_reg(REG_GENERATION, gens[i]);
      m = good_msg(CMD_OBS);
      m.msg_generation = ~cfg_gen;
      send_msg(m);
      run_cycle();
      settle();
    end
  endtask

  task automatic test_random_traffic();
    int good;
    good = 0;
    while (good < 480) begin
      if (good == 200) hold_reqs++;
      if ($urandom_range(0, 9) == 0) begin
        send_msg(noise_msg());
      end else begin
        good++;
        case (ph)
          AWAIT_OBS: send_msg(good_msg(CMD_OBS));
          AWAIT_BARRIER: begin
            if (ctrl_v && $urandom_range(0, 4) == 0) send_msg(good_msg(CMD_CTRL));
            else if (q_v && $urandom_range(0, 4) == 0) send_msg(good_msg(CMD_QUEUED));
            else if (ctrl_v) send_msg(good_msg(CMD_QUEUED));
            else if (q_v) send_msg(good_msg(CMD_CTRL));
            else send_msg(good_msg($urandom_range(0, 1) ? CMD_CTRL : CMD_QUEUED));
          end
          default: begin
            if ($urandom_range(0, 7) == 0)
              send_msg(good_msg($urandom_range(0, 1) ? CMD_CTRL : CMD_QUEUED));
            else
              send_msg(good_msg(CMD_PLANT));
          end
        endcase
      end
    end
    settle();
  endtask

  // drive into a random phase, break at most one field per message until the machine halts or 40 tries are used
  task automatic test_abort();
    in_t m;
    int tries;
    int lead;
    lead = $urandom_range(0, 3);
    if (lead > 0) send_msg(good_msg(CMD_OBS));
    if (lead > 1) send_msg(good_msg(CMD_CTRL));
    if (lead > 2) send_msg(good_msg(CMD_QUEUED));
    tries = 0;
    while (ph != HALTED && tries < 40) begin
      tries++;
      m = good_msg(cmd_t'($urandom_range(0, 3)));
      case ($urandom_range(0, 9))
        0: m.step ^= 32'd1 << $urandom_range(0, 31);
        1: m.src_step ^= 32'd1 << $urandom_range(0, 31);
        2: m.time_ns ^= 63'd1 << $urandom_range(0, 62);
        3: m.cmd_id ^= 32'd1 << $urandom_range(0, 31);
        4: m.ok_flag = ~m.ok_flag;
        5: m.plant_iter ^= 32'd1 << $urandom_range(0, 31);
        6: m.plant_time_ns ^= 63'd1 << $urandom_range(0, 62);
        7: m.applied_cmd ^= 32'd1 << $urandom_range(0, 31);
        8: m.obs_id ^= 64'd1 << $urandom_range(0, 63);
        default: ;
      endcase
      send_msg(m);
    end
    for (int i = 0; i < 12; i++) send_msg(good_msg(cmd_t'(i % 4)));
    settle();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_cnt = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      mode_cnt++;
      if (mode_cnt >= 64) begin
        mode_cnt = 0;
        stall_mode = $urandom_range(0, 2);
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_t exp_r;
    bit bad;
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        errors++;
        $display("unexpected result: %p", out_data);
      end else begin
        exp_r = result_q.pop_front();
        bad = exp_r.outcome != out_data.outcome
           || exp_r.abort_reason != out_data.abort_reason
           || exp_r.out_step != out_data.out_step
           || exp_r.out_time_ns != out_data.out_time_ns
           || exp_r.out_cmd_id != out_data.out_cmd_id
           || exp_r.out_obs_id != out_data.out_obs_id
           || exp_r.clock_sec != out_data.clock_sec
           || exp_r.clock_nanosec != out_data.clock_nanosec;
        if (bad) begin
          errors++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch expected %p", exp_r);
            $display("         actual   %p", out_data);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress, %0d results outstanding", result_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_basic_cycle();
    test_config_sweep();
    test_random_traffic();
    test_abort();
    if (result_q.size() != 0) errors++;
    $display("covered %0d messages: %0d grants, %0d commits, %0d aborts",
             n_sent, n_grants, n_commits, n_aborts);
    $display("step sizes from zero to one second, generations at both extremes");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== lockstep_step_barrier.f =====
hdl/lsb_pkg.sv
hdl/lsb_front.sv
hdl/lsb_back.sv
hdl/lockstep_step_barrier.sv
dv/lockstep_step_barrier_tb.sv
